>>> hdl/ultrasonic_hand_gesture_detector_defines.svh
// Assertion macros shared by the detector RTL.
`ifndef ULTRASONIC_HAND_GESTURE_DETECTOR_DEFINES_SVH
`define ULTRASONIC_HAND_GESTURE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define UHGD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define UHGD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UHGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UHGD_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define UHGD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define UHGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hdl/uhgd_pkg.sv
package uhgd_pkg;

   typedef struct packed {
      logic [14:0] echo_us;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [1:0] sensor;
      logic [6:0] level;
      logic       last;
   } rsp_type;

   // Event codes.
   localparam logic [2:0] EV_ON      = 3'd0;
   localparam logic [2:0] EV_LEVEL   = 3'd1;
   localparam logic [2:0] EV_OFF     = 3'd2;
   localparam logic [2:0] EV_TAP     = 3'd3;
   localparam logic [2:0] EV_SWIPE_R = 3'd4;
   localparam logic [2:0] EV_SWIPE_L = 3'd5;

   // Register indexes.
   localparam logic [2:0] CSR_TAP_MIN_HOLD   = 3'd0;
   localparam logic [2:0] CSR_LONG_HOLD      = 3'd1;
   localparam logic [2:0] CSR_TAP_MAX_SPREAD = 3'd2;
   localparam logic [2:0] CSR_TAP_MAX_NEAR   = 3'd3;
   localparam logic [2:0] CSR_SWIPE_WINDOW   = 3'd4;

   localparam logic [6:0]  FULL_LEVEL = 7'd127;
   localparam logic [4:0]  MIN_CM     = 5'd2;
   // A hand is seen for widths from 2*58 to 20*58+57 microseconds.
   localparam logic [14:0] ECHO_SEEN_MIN = 15'd116;
   localparam logic [14:0] ECHO_SEEN_MAX = 15'd1217;
   // Reciprocal of 58 scaled by 2^16; exact for widths up to ECHO_SEEN_MAX.
   localparam logic [10:0] CM_RECIP = 11'd1130;

   // Level for distance offsets 0 to 18 cm: floor(x * 127 / 18).
   function automatic logic [6:0] level_of(input logic [4:0] x);
      logic [6:0] r;
      unique case (x)
         5'd0:    r = 7'd0;
         5'd1:    r = 7'd7;
         5'd2:    r = 7'd14;
         5'd3:    r = 7'd21;
         5'd4:    r = 7'd28;
         5'd5:    r = 7'd35;
         5'd6:    r = 7'd42;
         5'd7:    r = 7'd49;
         5'd8:    r = 7'd56;
         5'd9:    r = 7'd63;
         5'd10:   r = 7'd70;
         5'd11:   r = 7'd77;
         5'd12:   r = 7'd84;
         5'd13:   r = 7'd91;
         5'd14:   r = 7'd98;
         5'd15:   r = 7'd105;
         5'd16:   r = 7'd112;
         5'd17:   r = 7'd119;
         5'd18:   r = 7'd127;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/ultrasonic_hand_gesture_detector.sv
// Channel   Ports                              Direction  Content
// request   req_valid / req_ready / req_data   in         one echo width and timestamp
// response  rsp_valid / rsp_ready / rsp_data   out        one gesture event
// csr       csr_wr_en / csr_index / csr_wdata  in         register write, no read-back
//
// An accepted item waits in the input stage until the event buffer is free, and is
// decoded there; its events are registered into the event buffer and offered from it.
// An item that produces zero to three events holds the event buffer until the last is
// taken, so the rate is one item per cycle for single events while rsp_ready stays high.
// Reset is synchronous and clears all sensor state and the registers to their defaults.
// A stalled response side holds the event buffer; one more item waits in the input stage.
`include "ultrasonic_hand_gesture_detector_defines.svh"

module ultrasonic_hand_gesture_detector
   import uhgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [15:0] tap_min_hold_ff;
   logic [15:0] long_hold_ff;
   logic [4:0]  tap_max_spread_ff;
   logic [4:0]  tap_max_near_ff;
   logic [15:0] swipe_window_ff;

   // Input stage.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;

   // Per-sensor tracking state.
   logic [1:0]  turn_ff, turn_in;
   logic [2:0]  hand_ff, hand_in;
   logic [2:0]  level_mode_ff, level_mode_in;
   logic [31:0] hold_start_ff [3];
   logic [31:0] hold_start_in [3];
   logic [4:0]  nearest_ff [3];
   logic [4:0]  nearest_in [3];
   logic [4:0]  farthest_ff [3];
   logic [4:0]  farthest_in [3];
   logic        origin_valid_ff, origin_valid_in;
   logic [1:0]  origin_sensor_ff, origin_sensor_in;
   logic [31:0] origin_ms_ff, origin_ms_in;

   // Event buffer holding the results of one item.
   rsp_type     evbuf_ff [3];
   rsp_type     evbuf_in [3];
   logic [1:0]  count_ff, count_in;
   logic [1:0]  rd_ff, rd_in;

   // Decode signals.
   logic        buf_free;
   logic        advance;
   logic [1:0]  cur;
   logic [21:0] cm_product;
   logic [4:0]  dist_cm;
   logic        seen;
   logic [31:0] hold_ms;
   logic [4:0]  spread_cm;
   logic        ev_on, ev_level, ev_off, ev_tap, ev_swipe, swipe_right;
   logic        swipe_found;
   logic [1:0]  n_ev;
   rsp_type     ev_list [3];

   // Conditions watched by the checks at the end.
   logic        rd_last;
   logic        rd_in_range;
   logic        in_stall;
   logic        in_kept;
   logic        last_ok;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_min_hold_ff   <= 16'd50;
         long_hold_ff      <= 16'd250;
         tap_max_spread_ff <= 5'd6;
         tap_max_near_ff   <= 5'd6;
         swipe_window_ff   <= 16'd250;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TAP_MIN_HOLD:   tap_min_hold_ff   <= csr_wdata;
            CSR_LONG_HOLD:      long_hold_ff      <= csr_wdata;
            CSR_TAP_MAX_SPREAD: tap_max_spread_ff <= csr_wdata[4:0];
            CSR_TAP_MAX_NEAR:   tap_max_near_ff   <= csr_wdata[4:0];
            CSR_SWIPE_WINDOW:   swipe_window_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The buffer frees up in the cycle its final event is taken, so a new item can be
   // decoded straight behind it.
   assign buf_free  = (count_ff == 2'd0) || (rsp_ready && (rd_ff == count_ff - 2'd1));
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = evbuf_ff[rd_ff];

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Distance is only needed inside the seen range, where an 11-bit reciprocal
   // multiply gives the exact quotient.
   assign cur        = turn_ff;
   assign cm_product = 22'(in_data_ff.echo_us[10:0]) * 22'(CM_RECIP);
   assign dist_cm    = cm_product[20:16];
   assign seen       = (in_data_ff.echo_us >= ECHO_SEEN_MIN) &&
                       (in_data_ff.echo_us <= ECHO_SEEN_MAX);
   assign hold_ms    = in_data_ff.now_ms - hold_start_ff[cur];
   assign spread_cm  = (farthest_ff[cur] >= nearest_ff[cur]) ?
                       (farthest_ff[cur] - nearest_ff[cur]) : 5'd0;

   // State update for the sensor whose turn it is, followed by the swipe check on the
   // updated presence flags.
   always_comb begin
      turn_in          = turn_ff;
      hand_in          = hand_ff;
      level_mode_in    = level_mode_ff;
      hold_start_in    = hold_start_ff;
      nearest_in       = nearest_ff;
      farthest_in      = farthest_ff;
      origin_valid_in  = origin_valid_ff;
      origin_sensor_in = origin_sensor_ff;
      origin_ms_in     = origin_ms_ff;
      ev_on            = 1'b0;
      ev_level         = 1'b0;
      ev_off           = 1'b0;
      ev_tap           = 1'b0;
      ev_swipe         = 1'b0;
      swipe_right      = 1'b0;
      swipe_found      = 1'b0;
      if (advance) begin
         turn_in = (turn_ff == 2'd2) ? 2'd0 : turn_ff + 2'd1;
         if (seen && !hand_ff[cur]) begin
            // A fresh hand: zero hold time, so no level report yet.
            hand_in[cur]       = 1'b1;
            level_mode_in[cur] = 1'b0;
            hold_start_in[cur] = in_data_ff.now_ms;
            nearest_in[cur]    = dist_cm;
            farthest_in[cur]   = dist_cm;
            ev_on              = 1'b1;
            origin_valid_in    = 1'b1;
            origin_sensor_in   = cur;
            origin_ms_in       = in_data_ff.now_ms;
         end else if (seen && hand_ff[cur]) begin
            if (level_mode_ff[cur] || (hold_ms > {16'd0, long_hold_ff})) begin
               level_mode_in[cur] = 1'b1;
               ev_level           = 1'b1;
               if (dist_cm < nearest_ff[cur]) begin
                  nearest_in[cur] = dist_cm;
               end
               if (dist_cm > farthest_ff[cur]) begin
                  farthest_in[cur] = dist_cm;
               end
            end
         end else if (!seen && hand_ff[cur]) begin
            hand_in[cur]       = 1'b0;
            level_mode_in[cur] = 1'b0;
            ev_off             = 1'b1;
            ev_tap = (hold_ms >= {16'd0, tap_min_hold_ff}) &&
                     (hold_ms <= {16'd0, long_hold_ff}) &&
                     (spread_cm <= tap_max_spread_ff) &&
                     (nearest_ff[cur] <= tap_max_near_ff);
         end
         if (origin_valid_in) begin
            for (int s = 0; s < 3; s++) begin
               if (!swipe_found && hand_in[s] && (2'(s) != origin_sensor_in)) begin
                  swipe_found     = 1'b1;
                  origin_valid_in = 1'b0;
                  swipe_right     = origin_sensor_in < 2'(s);
                  ev_swipe = (in_data_ff.now_ms - origin_ms_in) < {16'd0, swipe_window_ff};
               end
            end
         end
      end
   end

   // Pack the events of this item in order and mark the final one.
   always_comb begin
      n_ev = 2'd0;
      for (int k = 0; k < 3; k++) begin
         ev_list[k] = '0;
      end
      if (ev_on) begin
         ev_list[n_ev] = '{EV_ON, cur, FULL_LEVEL, 1'b0};
         n_ev = n_ev + 2'd1;
      end
      if (ev_level) begin
         ev_list[n_ev] = '{EV_LEVEL, cur, level_of(dist_cm - MIN_CM), 1'b0};
         n_ev = n_ev + 2'd1;
      end
      if (ev_off) begin
         ev_list[n_ev] = '{EV_OFF, cur, 7'd0, 1'b0};
         n_ev = n_ev + 2'd1;
      end
      if (ev_tap) begin
         ev_list[n_ev] = '{EV_TAP, cur, FULL_LEVEL, 1'b0};
         n_ev = n_ev + 2'd1;
      end
      if (ev_swipe) begin
         ev_list[n_ev] = '{(swipe_right ? EV_SWIPE_R : EV_SWIPE_L), 2'd1, FULL_LEVEL, 1'b0};
         n_ev = n_ev + 2'd1;
      end
      for (int k = 0; k < 3; k++) begin
         ev_list[k].last = (2'(k) == n_ev - 2'd1);
      end
   end

   always_comb begin
      evbuf_in = evbuf_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      if (rsp_valid && rsp_ready) begin
         if (rd_ff == count_ff - 2'd1) begin
            count_in = 2'd0;
            rd_in    = 2'd0;
         end else begin
            rd_in = rd_ff + 2'd1;
         end
      end
      if (advance && (n_ev != 2'd0)) begin
         evbuf_in = ev_list;
         count_in = n_ev;
         rd_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         turn_ff          <= 2'd0;
         hand_ff          <= 3'd0;
         level_mode_ff    <= 3'd0;
         origin_valid_ff  <= 1'b0;
         origin_sensor_ff <= 2'd0;
         origin_ms_ff     <= 32'd0;
         count_ff         <= 2'd0;
         rd_ff            <= 2'd0;
         for (int k = 0; k < 3; k++) begin
            hold_start_ff[k] <= 32'd0;
            nearest_ff[k]    <= 5'd0;
            farthest_ff[k]   <= 5'd0;
         end
      end else begin
         in_valid_ff      <= in_valid_in;
         turn_ff          <= turn_in;
         hand_ff          <= hand_in;
         level_mode_ff    <= level_mode_in;
         origin_valid_ff  <= origin_valid_in;
         origin_sensor_ff <= origin_sensor_in;
         origin_ms_ff     <= origin_ms_in;
         count_ff         <= count_in;
         rd_ff            <= rd_in;
         hold_start_ff    <= hold_start_in;
         nearest_ff       <= nearest_in;
         farthest_ff      <= farthest_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      evbuf_ff   <= evbuf_in;
   end

   // A waiting item must still be there, unchanged, after the next edge.
   assign rd_last     = (rd_ff == count_ff - 2'd1);
   assign rd_in_range = (count_ff == 2'd0) || (rd_ff < count_ff);
   assign in_stall    = in_valid_ff && !advance;
   assign in_kept     = in_valid_in && (in_data_in == in_data_ff);
   assign last_ok     = !rsp_valid || (rsp_data.last == rd_last);

   `UHGD_ASSERT_ALWAYS(a_read_in_range, clock, reset, rd_in_range, "read pointer past events")
   `UHGD_ASSERT_ALWAYS(a_turn_range, clock, reset, turn_ff != 2'd3, "sensor turn out of range")
   `UHGD_ASSERT_IMPLIES(a_held_item, clock, reset, in_stall, in_kept, "waiting item changed")
   `UHGD_ASSERT_ALWAYS(a_last_marks_end, clock, reset, last_ok, "last flag misplaced")

endmodule

>>> dv/ultrasonic_hand_gesture_detector_tb.sv
module ultrasonic_hand_gesture_detector_tb
   import uhgd_pkg::*;
();

   // Conversion and validity limits of an echo: width / 58 gives centimetres,
   // and only 2 to 20 cm inside the 25 ms timeout counts as a hand.
   localparam int unsigned CM_DIVISOR      = 58;
   localparam int unsigned ECHO_TIMEOUT_US = 25000;
   localparam int unsigned NEAREST_CM      = 2;
   localparam int unsigned FARTHEST_CM     = 20;
   localparam int unsigned NUM_SENSORS     = 3;
   localparam int unsigned SWIPE_SENSOR    = 1;

   // An index that names no register; writes to it must leave every setting alone.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // Run control. The stall limit sits far above the longest legal quiet spell,
   // which is a drain between phases plus a sender gap plus a receiver stall.
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int ITEMS_PER_PHASE = 84;
   localparam int DIRECTED_ITEMS  = 25;

   // The scoreboard keeps its own copy of the registers and of the per-sensor
   // gesture state, works out the events that each accepted measurement causes,
   // and checks the events that come out of the block in order.
   class gesture_scoreboard;
      logic [15:0] tap_min_hold;
      logic [15:0] long_hold;
      logic [4:0]  tap_max_spread;
      logic [4:0]  tap_max_near;
      logic [15:0] swipe_window;
      int unsigned turn;
      bit          present [NUM_SENSORS];
      bit          levelling [NUM_SENSORS];
      logic [31:0] hold_start [NUM_SENSORS];
      logic [4:0]  nearest [NUM_SENSORS];
      logic [4:0]  farthest [NUM_SENSORS];
      bit          origin_valid;
      int unsigned origin_sensor;
      logic [31:0] origin_ms;
      rsp_type     expected_events [$];
      int          mismatches;

      function new();
         tap_min_hold   = 16'd50;
         long_hold      = 16'd250;
         tap_max_spread = 5'd6;
         tap_max_near   = 5'd6;
         swipe_window   = 16'd250;
         turn           = 0;
         for (int k = 0; k < NUM_SENSORS; k++) begin
            present[k]    = 1'b0;
            levelling[k]  = 1'b0;
            hold_start[k] = '0;
            nearest[k]    = '0;
            farthest[k]   = '0;
         end
         origin_valid  = 1'b0;
         origin_sensor = 0;
         origin_ms     = '0;
         mismatches    = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_TAP_MIN_HOLD:   tap_min_hold   = value;
            CSR_LONG_HOLD:      long_hold      = value;
            CSR_TAP_MAX_SPREAD: tap_max_spread = value[4:0];
            CSR_TAP_MAX_NEAR:   tap_max_near   = value[4:0];
            CSR_SWIPE_WINDOW:   swipe_window   = value;
            default: ;
         endcase
      endfunction

      function rsp_type make_event(logic [2:0] code, int unsigned sensor, logic [6:0] level);
         rsp_type e;
         e.event_res = code;
         e.sensor    = sensor[1:0];
         e.level     = level;
         e.last      = 1'b0;
         return e;
      endfunction

      function void note_measurement(req_type m);
         rsp_type     burst [$];
         int unsigned i;
         int unsigned cm;
         bit          seen;
         bit          searching;
         logic [31:0] held;
         logic [4:0]  spread;
         i    = turn;
         turn = (i == NUM_SENSORS - 1) ? 0 : i + 1;
         cm   = m.echo_us / CM_DIVISOR;
         seen = m.echo_us != 0 && m.echo_us <= ECHO_TIMEOUT_US &&
                cm >= NEAREST_CM && cm <= FARTHEST_CM;

         // A new hand opens a hold and also becomes the origin of a possible swipe.
         if (seen && !present[i]) begin
            present[i]    = 1'b1;
            levelling[i]  = 1'b0;
            hold_start[i] = m.now_ms;
            nearest[i]    = cm[4:0];
            farthest[i]   = cm[4:0];
            burst.push_back(make_event(EV_ON, i, FULL_LEVEL));
            origin_valid  = 1'b1;
            origin_sensor = i;
            origin_ms     = m.now_ms;
         end

         // Past the long-hold limit the sensor reports its distance continuously,
         // and only then are the nearest and farthest distances widened.
         if (seen && present[i]) begin
            held = m.now_ms - hold_start[i];
            if (!levelling[i] && held > 32'(long_hold))
               levelling[i] = 1'b1;
            if (levelling[i]) begin
               if (cm[4:0] < nearest[i])
                  nearest[i] = cm[4:0];
               if (cm[4:0] > farthest[i])
                  farthest[i] = cm[4:0];
               burst.push_back(make_event(EV_LEVEL, i,
                  7'((cm - NEAREST_CM) * 127 / (FARTHEST_CM - NEAREST_CM))));
            end
         end

         // Release: always an off event, and a tap when the hold was short, close and steady.
         if (!seen && present[i]) begin
            held         = m.now_ms - hold_start[i];
            spread       = (farthest[i] >= nearest[i]) ? farthest[i] - nearest[i] : 5'd0;
            present[i]   = 1'b0;
            levelling[i] = 1'b0;
            burst.push_back(make_event(EV_OFF, i, 7'd0));
            if (held >= 32'(tap_min_hold) && held <= 32'(long_hold) &&
                spread <= tap_max_spread && nearest[i] <= tap_max_near)
               burst.push_back(make_event(EV_TAP, i, FULL_LEVEL));
         end

         // The lowest-numbered other sensor holding a hand closes the swipe origin;
         // it only makes a swipe when it came inside the window.
         if (origin_valid) begin
            searching = 1'b1;
            for (int unsigned s = 0; s < NUM_SENSORS; s++) begin
               if (searching && present[s] && s != origin_sensor) begin
                  if (m.now_ms - origin_ms < 32'(swipe_window))
                     burst.push_back(make_event(origin_sensor < s ? EV_SWIPE_R : EV_SWIPE_L,
                                                SWIPE_SENSOR, FULL_LEVEL));
                  origin_valid = 1'b0;
                  searching    = 1'b0;
               end
            end
         end

         if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
         foreach (burst[k])
            expected_events.push_back(burst[k]);
      endfunction

      function void check_event(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            $error("unexpected event: event_res %0d sensor %0d level %0d last %0d",
                   got.event_res, got.sensor, got.level, got.last);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
            mismatches++;
         end
         if (got.sensor !== want.sensor) begin
            $error("sensor: expected %0d, actual %0d", want.sensor, got.sensor);
            mismatches++;
         end
         if (got.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, got.level);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [15:0] csr_wdata   = '0;

   gesture_scoreboard board;

   // Set for the closing phase, in which neither side idles.
   bit          steady = 1'b0;
   int          stall_left = 0;
   int unsigned sent_items = 0;
   logic [31:0] clock_ms = '0;

   // Each sensor follows its own hand: a count of further visits on which the
   // hand stays in view, and the distance it hovers at.
   int unsigned hand_turns [NUM_SENSORS] = '{0, 0, 0};
   int unsigned hand_cm [NUM_SENSORS]    = '{0, 0, 0};

   // The opening items, 30 ms apart, run through the sensors in turn (left,
   // centre, right). They start just short of the timestamp wrap, so the hold
   // arithmetic crosses it. Along the way they cover: a hand at the nearest and
   // the farthest valid distance, widths just outside the valid span, no echo,
   // a width at and just over the timeout, the widest possible width, a tap on
   // release, a right and a left swipe, level reports at both ends of the scale,
   // and releases that are too long or too far away to count as taps.
   int unsigned directed_echo [DIRECTED_ITEMS] = '{
      116,   0,     25001,
      200,   115,   32767,
      0,     1217,  1218,
      600,   1217,  25000,
      600,   900,   0,
      600,   900,   1000,
      1217,  0,     1000,
      116,   0,     0,
      0
   };

   ultrasonic_hand_gesture_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Builds the next random measurement for the sensor whose turn it is. Most
   // items follow the planned hand of that sensor, so that holds, level reports,
   // taps and swipes come about; a few are pure noise across the whole width.
   function automatic req_type next_measurement();
      req_type     m;
      int unsigned s;
      int unsigned pick;
      int          cm;
      logic [14:0] echo;
      s    = sent_items % NUM_SENSORS;
      pick = $urandom_range(0, 99);
      if (pick < 75)
         clock_ms += $urandom_range(0, 60);
      else if (pick < 93)
         clock_ms += $urandom_range(60, 400);
      else if (pick < 97)
         clock_ms += 0;
      else
         clock_ms += $urandom;

      if ($urandom_range(0, 99) < 6) begin
         echo = 15'($urandom_range(0, 32767));
      end else if (hand_turns[s] > 0) begin
         hand_turns[s]--;
         cm = int'(hand_cm[s]);
         if ($urandom_range(0, 2) == 0)
            cm = cm + int'($urandom_range(0, 4)) - 2;
         if (cm < int'(NEAREST_CM))
            cm = NEAREST_CM;
         if (cm > int'(FARTHEST_CM))
            cm = FARTHEST_CM;
         echo = 15'(cm * CM_DIVISOR + $urandom_range(0, CM_DIVISOR - 1));
      end else begin
         // No hand on this visit: mostly silence, sometimes an echo outside the span.
         case ($urandom_range(0, 9))
            6:       echo = 15'($urandom_range(1, 115));
            7:       echo = 15'($urandom_range(1218, 25000));
            8:       echo = 15'($urandom_range(25001, 32767));
            9:       echo = 15'(ECHO_TIMEOUT_US);
            default: echo = '0;
         endcase
         if ($urandom_range(0, 2) == 0) begin
            hand_turns[s] = $urandom_range(1, 9);
            hand_cm[s]    = $urandom_range(0, 1) ? $urandom_range(2, 7) : $urandom_range(2, 20);
         end
      end
      m.echo_us = echo;
      m.now_ms  = clock_ms;
      return m;
   endfunction

   // Offers one item and waits for it to be taken. Valid stays high across
   // back-to-back items; it only drops for a sender gap.
   task automatic send_measurement(input req_type m);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do
         @(posedge clock);
      while (!req_ready);
      board.note_measurement(m);
      sent_items++;
   endtask

   // Leaves the block idle: every expected event out, then a few more cycles in
   // case the last item is still being decoded without producing anything.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   // Writes all five registers, plus one write to an unused index that the block
   // has to ignore.
   task automatic configure(input logic [15:0] min_hold, input logic [15:0] max_hold,
                            input logic [15:0] spread, input logic [15:0] near,
                            input logic [15:0] window);
      write_register(CSR_TAP_MIN_HOLD, min_hold);
      write_register(CSR_LONG_HOLD, max_hold);
      write_register(CSR_TAP_MAX_SPREAD, spread);
      write_register(CSR_TAP_MAX_NEAR, near);
      write_register(CSR_SWIPE_WINDOW, window);
      write_register(CSR_UNUSED, 16'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_measurement(next_measurement());
   endtask

   // Result side: every event taken is checked against the oldest expectation.
   // Ready drops for random stalls, except in the closing phase.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_event(rsp_data);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: a long run of cycles with no item moving on either side means the
   // block has hung.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("ultrasonic_hand_gesture_detector regression: fail");
      $finish;
   end

   initial begin : stimulus
      req_type m;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed items with the registers still at their reset values.
      clock_ms = 32'hFFFF_FFC0;
      for (int k = 0; k < DIRECTED_ITEMS; k++) begin
         m.echo_us = 15'(directed_echo[k]);
         m.now_ms  = clock_ms;
         send_measurement(m);
         clock_ms += 30;
      end
      send_random(ITEMS_PER_PHASE);

      // Everything at zero: any hold at all reports levels, taps and swipes are
      // impossible.
      settle();
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_random(ITEMS_PER_PHASE);

      // Everything at its top; the narrow registers see all their write bits set.
      settle();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_random(ITEMS_PER_PHASE);

      // Random settings in a useful band, with the timestamp about to wrap.
      settle();
      configure(16'($urandom_range(0, 120)), 16'($urandom_range(120, 500)),
                16'($urandom_range(0, 31)), 16'($urandom_range(2, 31)),
                16'($urandom_range(30, 600)));
      clock_ms = 32'hFFFF_F000;
      send_random(ITEMS_PER_PHASE);

      // Closing phase: back to the reset values and full throughput on both sides.
      settle();
      steady = 1'b1;
      configure(16'd50, 16'd250, 16'd6, 16'd6, 16'd250);
      send_random(ITEMS_PER_PHASE + 20);

      req_valid <= 1'b0;
      while (board.expected_events.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("ultrasonic_hand_gesture_detector regression: pass");
      else
         $display("ultrasonic_hand_gesture_detector regression: fail");
      $finish;
   end

endmodule
